FILE: src/gcni_pkg.sv
package gcni_pkg;

    localparam int CELL_W    = 30;
    localparam int DIR_W     = 3;
    localparam int REG_W     = 11;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [DIR_W-1:0] {
        DIR_X_MINUS = 3'd0,
        DIR_X_PLUS  = 3'd1,
        DIR_Y_MINUS = 3'd2,
        DIR_Y_PLUS  = 3'd3,
        DIR_Z_MINUS = 3'd4,
        DIR_Z_PLUS  = 3'd5
    } t_dir;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_OUTSIDE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_X_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Z_SIZE = 2'd2;

endpackage

FILE: src/gcni_if.sv
interface gcni_req_if;
    logic                         valid;
    logic                         ready;
    logic [gcni_pkg::CELL_W-1:0]  cell_req;
    logic [gcni_pkg::DIR_W-1:0]   direction;

    modport source (output valid, output cell_req, output direction, input ready);
    modport sink   (input valid, input cell_req, input direction, output ready);
endinterface

interface gcni_rsp_if #(
    parameter int DIM_BITS = 10
);
    logic                         valid;
    logic                         ready;
    logic                         status;
    logic [DIM_BITS-1:0]          coord_x;
    logic [DIM_BITS-1:0]          coord_y;
    logic [DIM_BITS-1:0]          coord_z;
    logic                         has_neighbor;
    logic [gcni_pkg::CELL_W-1:0]  neighbor_cell;

    modport source (output valid, output status, output coord_x, output coord_y,
                    output coord_z, output has_neighbor, output neighbor_cell,
                    input ready);
    modport sink   (input valid, input status, input coord_x, input coord_y,
                    input coord_z, input has_neighbor, input neighbor_cell,
                    output ready);
endinterface

interface gcni_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [gcni_pkg::CFG_IDX_W-1:0]  index;
    logic [gcni_pkg::REG_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/grid_cell_neighbor_index_unit.sv
// Grid cell neighbor index unit.
// Request channel i_req carries a linear cell number (x fastest) and a face
// direction. Response channel o_rsp returns status, the cell's x/y/z
// coordinates, a neighbor-exists flag and the neighbor's linear number.
// Config channel i_cfg writes x_size, y_size, z_size (index 0, 1, 2); it is
// always ready and must only be used while no request is in flight.
// Throughput: one request per cycle while the skid register is empty. The
// result passes through the restoring dividers: one stage per quotient bit,
// 30 stages for cell / (x_size*y_size) and DIM_BITS stages for the
// remainder / x_size, plus input, decode and output registers. Sizes above
// 2**DIM_BITS are used as 2**DIM_BITS.
// Reset: sizes return to 1, all pipeline valid bits clear.
// Receiver stall: a skid register catches the result at the head; the
// pipeline freezes while it is full and resumes without loss or repeat.
// Cells at or beyond x_size*y_size*z_size return status 1 with zero fields.
module grid_cell_neighbor_index_unit #(
    parameter int DIM_BITS = 10
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gcni_req_if.sink     i_req,
    gcni_rsp_if.source   o_rsp,
    gcni_cfg_if.sink     i_cfg
);

    localparam int CW  = gcni_pkg::CELL_W;
    localparam int RW  = gcni_pkg::REG_W;
    localparam int DW  = gcni_pkg::DIR_W;
    localparam int SW  = DIM_BITS + 1;
    localparam int XW  = (SW > RW) ? SW : RW;
    localparam int PW  = 2 * DIM_BITS + 1;
    localparam int NW  = DIM_BITS + 1;
    localparam logic [XW-1:0] LIM = XW'(1) << DIM_BITS;

    typedef struct packed {
        logic                status;
        logic [DIM_BITS-1:0] coord_x;
        logic [DIM_BITS-1:0] coord_y;
        logic [DIM_BITS-1:0] coord_z;
        logic                has_neighbor;
        logic [CW-1:0]       neighbor_cell;
    } t_rsp;

    function automatic logic [SW-1:0] f_eff(input logic [RW-1:0] v);
        logic [XW-1:0] ext;
        ext = XW'(v);
        return SW'((ext > LIM) ? LIM : ext);
    endfunction

    // configuration
    logic [RW-1:0] r_x_size;
    logic [RW-1:0] r_y_size;
    logic [RW-1:0] r_z_size;
    logic [PW-1:0] r_plane;
    logic [SW-1:0] w_nx;
    logic [SW-1:0] w_ny;
    logic [SW-1:0] w_nz;

    assign i_cfg.ready = 1'b1;
    assign w_nx = f_eff(r_x_size);
    assign w_ny = f_eff(r_y_size);
    assign w_nz = f_eff(r_z_size);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_size <= RW'(1);
            r_y_size <= RW'(1);
            r_z_size <= RW'(1);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                gcni_pkg::REG_X_SIZE: r_x_size <= i_cfg.data;
                gcni_pkg::REG_Y_SIZE: r_y_size <= i_cfg.data;
                gcni_pkg::REG_Z_SIZE: r_z_size <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_plane <= PW'(w_nx * w_ny);
    end

    // pipeline control
    logic r_skid_v;
    logic w_en;
    assign w_en        = !r_skid_v;
    assign i_req.ready = w_en;

    // divider 1: cell / plane, one quotient bit per stage
    logic [PW-1:0] r_d1_rem  [0:CW];
    logic [CW-1:0] r_d1_quo  [0:CW];
    logic [CW-1:0] r_d1_cell [0:CW];
    logic [DW-1:0] r_d1_dir  [0:CW];
    logic          r_d1_vld  [0:CW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_d1_vld[0] <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d1_rem[0]  <= '0;
            r_d1_quo[0]  <= i_req.cell_req;
            r_d1_cell[0] <= i_req.cell_req;
            r_d1_dir[0]  <= i_req.direction;
        end
    end

    for (genvar s = 0; s < CW; s++) begin : g_div1
        logic [PW-1:0] w_sh;
        logic [PW:0]   w_diff;
        logic          w_ge;
        logic [PW-1:0] n_rem;

        assign w_sh   = {r_d1_rem[s][PW-2:0], r_d1_quo[s][CW-1]};
        assign w_diff = {1'b0, w_sh} - {1'b0, r_plane};
        assign w_ge   = !w_diff[PW];
        assign n_rem  = w_ge ? w_diff[PW-1:0] : w_sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d1_vld[s+1] <= 1'b0;
            end else if (w_en) begin
                r_d1_vld[s+1] <= r_d1_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_d1_rem[s+1]  <= n_rem;
                r_d1_quo[s+1]  <= {r_d1_quo[s][CW-2:0], w_ge};
                r_d1_cell[s+1] <= r_d1_cell[s];
                r_d1_dir[s+1]  <= r_d1_dir[s];
            end
        end
    end

    // divider 2: remainder / nx, quotient fits DIM_BITS
    logic [NW-1:0]       r_d2_rem  [0:DIM_BITS];
    logic [DIM_BITS-1:0] r_d2_quo  [0:DIM_BITS];
    logic [CW-1:0]       r_d2_k    [0:DIM_BITS];
    logic [CW-1:0]       r_d2_cell [0:DIM_BITS];
    logic [DW-1:0]       r_d2_dir  [0:DIM_BITS];
    logic                r_d2_vld  [0:DIM_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d2_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_d2_vld[0] <= r_d1_vld[CW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d2_rem[0]  <= {1'b0, r_d1_rem[CW][PW-2:DIM_BITS]};
            r_d2_quo[0]  <= r_d1_rem[CW][DIM_BITS-1:0];
            r_d2_k[0]    <= r_d1_quo[CW];
            r_d2_cell[0] <= r_d1_cell[CW];
            r_d2_dir[0]  <= r_d1_dir[CW];
        end
    end

    for (genvar s = 0; s < DIM_BITS; s++) begin : g_div2
        logic [NW-1:0] w_sh;
        logic [NW:0]   w_diff;
        logic          w_ge;
        logic [NW-1:0] n_rem;

        assign w_sh   = {r_d2_rem[s][NW-2:0], r_d2_quo[s][DIM_BITS-1]};
        assign w_diff = {1'b0, w_sh} - {1'b0, w_nx};
        assign w_ge   = !w_diff[NW];
        assign n_rem  = w_ge ? w_diff[NW-1:0] : w_sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d2_vld[s+1] <= 1'b0;
            end else if (w_en) begin
                r_d2_vld[s+1] <= r_d2_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_d2_rem[s+1]  <= n_rem;
                if (DIM_BITS > 1) begin
                    r_d2_quo[s+1] <= {r_d2_quo[s][DIM_BITS-2:0], w_ge};
                end else begin
                    r_d2_quo[s+1] <= DIM_BITS'(w_ge);
                end
                r_d2_k[s+1]    <= r_d2_k[s];
                r_d2_cell[s+1] <= r_d2_cell[s];
                r_d2_dir[s+1]  <= r_d2_dir[s];
            end
        end
    end

    // decode: range check and neighbor selection
    logic [DIM_BITS-1:0] w_i;
    logic [DIM_BITS-1:0] w_j;
    logic [DIM_BITS-1:0] w_k;
    logic                n_err;
    logic                n_has;
    logic                n_sub;
    logic [CW-1:0]       n_off;

    assign w_i   = r_d2_rem[DIM_BITS][DIM_BITS-1:0];
    assign w_j   = r_d2_quo[DIM_BITS];
    assign w_k   = r_d2_k[DIM_BITS][DIM_BITS-1:0];
    assign n_err = r_d2_k[DIM_BITS] >= CW'(w_nz);

    always_comb begin
        n_has = 1'b0;
        n_sub = 1'b0;
        n_off = '0;
        case (r_d2_dir[DIM_BITS])
            gcni_pkg::DIR_X_MINUS: begin
                n_has = (w_i != '0);
                n_sub = 1'b1;
                n_off = CW'(1);
            end
            gcni_pkg::DIR_X_PLUS: begin
                n_has = (NW'(w_i) + NW'(1)) < w_nx;
                n_off = CW'(1);
            end
            gcni_pkg::DIR_Y_MINUS: begin
                n_has = (w_j != '0);
                n_sub = 1'b1;
                n_off = CW'(w_nx);
            end
            gcni_pkg::DIR_Y_PLUS: begin
                n_has = (NW'(w_j) + NW'(1)) < w_ny;
                n_off = CW'(w_nx);
            end
            gcni_pkg::DIR_Z_MINUS: begin
                n_has = (w_k != '0);
                n_sub = 1'b1;
                n_off = CW'(r_plane);
            end
            gcni_pkg::DIR_Z_PLUS: begin
                n_has = (NW'(w_k) + NW'(1)) < w_nz;
                n_off = CW'(r_plane);
            end
            default: ;
        endcase
    end

    logic                r_f_vld;
    logic                r_f_err;
    logic                r_f_has;
    logic                r_f_sub;
    logic [CW-1:0]       r_f_off;
    logic [CW-1:0]       r_f_cell;
    logic [DIM_BITS-1:0] r_f_i;
    logic [DIM_BITS-1:0] r_f_j;
    logic [DIM_BITS-1:0] r_f_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (w_en) begin
            r_f_vld <= r_d2_vld[DIM_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_err  <= n_err;
            r_f_has  <= n_has && !n_err;
            r_f_sub  <= n_sub;
            r_f_off  <= n_off;
            r_f_cell <= r_d2_cell[DIM_BITS];
            r_f_i    <= w_i;
            r_f_j    <= w_j;
            r_f_k    <= w_k;
        end
    end

    // output register and skid
    t_rsp r_out;
    t_rsp r_skid;
    t_rsp n_out;
    t_rsp w_rsp;
    logic r_out_v;

    always_comb begin
        n_out = '0;
        if (r_f_err) begin
            n_out.status = gcni_pkg::STATUS_OUTSIDE;
        end else begin
            n_out.status       = gcni_pkg::STATUS_OK;
            n_out.coord_x      = r_f_i;
            n_out.coord_y      = r_f_j;
            n_out.coord_z      = r_f_k;
            n_out.has_neighbor = r_f_has;
            if (r_f_has) begin
                n_out.neighbor_cell = r_f_sub ? (r_f_cell - r_f_off) : (r_f_cell + r_f_off);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (w_en) begin
                r_out_v <= r_f_vld;
                if (r_out_v && !o_rsp.ready) begin
                    r_skid_v <= 1'b1;
                end
            end else if (o_rsp.ready) begin
                r_skid_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
            if (r_out_v && !o_rsp.ready) begin
                r_skid <= r_out;
            end
        end
    end

    assign w_rsp               = r_skid_v ? r_skid : r_out;
    assign o_rsp.valid         = r_skid_v || r_out_v;
    assign o_rsp.status        = w_rsp.status;
    assign o_rsp.coord_x       = w_rsp.coord_x;
    assign o_rsp.coord_y       = w_rsp.coord_y;
    assign o_rsp.coord_z       = w_rsp.coord_z;
    assign o_rsp.has_neighbor  = w_rsp.has_neighbor;
    assign o_rsp.neighbor_cell = w_rsp.neighbor_cell;

endmodule

FILE: src/gcni_checker.sv
module gcni_checker #(
    parameter int DIM_BITS = 10
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_rsp_valid,
    input logic                        i_rsp_ready,
    input logic                        i_status,
    input logic [DIM_BITS-1:0]         i_coord_x,
    input logic [DIM_BITS-1:0]         i_coord_y,
    input logic [DIM_BITS-1:0]         i_coord_z,
    input logic                        i_has_neighbor,
    input logic [gcni_pkg::CELL_W-1:0] i_neighbor_cell
);

    // stalled response keeps its payload
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_status)
            && $stable(i_coord_x) && $stable(i_coord_y) && $stable(i_coord_z)
            && $stable(i_has_neighbor) && $stable(i_neighbor_cell))
        else $error("response changed during stall");

    // outside cell gives all-zero fields
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_status == gcni_pkg::STATUS_OUTSIDE |->
            i_coord_x == '0 && i_coord_y == '0 && i_coord_z == '0
            && !i_has_neighbor && i_neighbor_cell == '0)
        else $error("outside cell with nonzero fields");

    // no neighbor means zero neighbor number
    a_absent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_has_neighbor |-> i_neighbor_cell == '0)
        else $error("absent neighbor with nonzero number");

    // nothing leaves right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("response valid after reset");

endmodule

bind grid_cell_neighbor_index_unit gcni_checker #(.DIM_BITS(DIM_BITS)) u_gcni_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_status        (o_rsp.status),
    .i_coord_x       (o_rsp.coord_x),
    .i_coord_y       (o_rsp.coord_y),
    .i_coord_z       (o_rsp.coord_z),
    .i_has_neighbor  (o_rsp.has_neighbor),
    .i_neighbor_cell (o_rsp.neighbor_cell)
);

FILE: verif/grid_cell_neighbor_index_unit_tb.sv
module grid_cell_neighbor_index_unit_tb;

    localparam int CELL_W    = gcni_pkg::CELL_W;
    localparam int REG_W     = gcni_pkg::REG_W;
    localparam int DIR_W     = gcni_pkg::DIR_W;
    localparam int CFG_IDX_W = gcni_pkg::CFG_IDX_W;

    localparam int DIM_BITS = 10;
    localparam int LATENCY = DIM_BITS + 33;
    localparam longint unsigned DIM_MAX = 64'd1 << DIM_BITS;
    localparam logic [CELL_W-1:0] CELL_MAX = '1;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER [3] =
        '{gcni_pkg::REG_X_SIZE, gcni_pkg::REG_Y_SIZE, gcni_pkg::REG_Z_SIZE};

    typedef struct packed {
        logic                status;
        logic [DIM_BITS-1:0] coord_x;
        logic [DIM_BITS-1:0] coord_y;
        logic [DIM_BITS-1:0] coord_z;
        logic                has_neighbor;
        logic [CELL_W-1:0]   neighbor_cell;
    } t_nbr_result;

    class grid_neighbor_scoreboard;
        logic [REG_W-1:0] size_reg [3];
        t_nbr_result      pending_results [$];
        int               errors;

        function new();
            size_reg = '{11'd1, 11'd1, 11'd1};
            errors = 0;
        endfunction

        // size as the block uses it: saturated at 2**DIM_BITS
        function longint unsigned dim(int axis);
            longint unsigned v;
            v = size_reg[axis];
            return (v > DIM_MAX) ? DIM_MAX : v;
        endfunction

        function void set_size(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
            case (idx)
                gcni_pkg::REG_X_SIZE: size_reg[0] = value;
                gcni_pkg::REG_Y_SIZE: size_reg[1] = value;
                gcni_pkg::REG_Z_SIZE: size_reg[2] = value;
                default: ;
            endcase
        endfunction

        function t_nbr_result locate_neighbor(logic [CELL_W-1:0] cell_num,
                                              logic [DIR_W-1:0] dir);
            longint unsigned nx, ny, nz, plane, count, c, i, j, k, rem, nb;
            bit has;
            t_nbr_result r;
            nx = dim(0);
            ny = dim(1);
            nz = dim(2);
            plane = nx * ny;
            count = plane * nz;
            c = cell_num;
            r = '0;
            if (c >= count) begin
                r.status = gcni_pkg::STATUS_OUTSIDE;
                return r;
            end
            k = c / plane;
            rem = c % plane;
            j = rem / nx;
            i = rem % nx;
            has = 0;
            nb = 0;
            case (dir)
                gcni_pkg::DIR_X_MINUS: if (i > 0)      begin has = 1; nb = c - 1;     end
                gcni_pkg::DIR_X_PLUS:  if (i + 1 < nx) begin has = 1; nb = c + 1;     end
                gcni_pkg::DIR_Y_MINUS: if (j > 0)      begin has = 1; nb = c - nx;    end
                gcni_pkg::DIR_Y_PLUS:  if (j + 1 < ny) begin has = 1; nb = c + nx;    end
                gcni_pkg::DIR_Z_MINUS: if (k > 0)      begin has = 1; nb = c - plane; end
                gcni_pkg::DIR_Z_PLUS:  if (k + 1 < nz) begin has = 1; nb = c + plane; end
                default: ;
            endcase
            r.status = gcni_pkg::STATUS_OK;
            r.coord_x = i[DIM_BITS-1:0];
            r.coord_y = j[DIM_BITS-1:0];
            r.coord_z = k[DIM_BITS-1:0];
            r.has_neighbor = has;
            r.neighbor_cell = nb[CELL_W-1:0];
            return r;
        endfunction

        function void note_lookup(logic [CELL_W-1:0] cell_num, logic [DIR_W-1:0] dir);
            pending_results.push_back(locate_neighbor(cell_num, dir));
        endfunction

        task report(string what, longint unsigned got, longint unsigned want);
            errors++;
            $display("mismatch %s: got %0d want %0d", what, got, want);
        endtask

        task check_result(t_nbr_result got);
            t_nbr_result want;
            if (pending_results.size() == 0) begin
                report("unexpected transfer, status", got.status, 0);
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status)
                report("status", got.status, want.status);
            if (got.coord_x !== want.coord_x)
                report("coord_x", got.coord_x, want.coord_x);
            if (got.coord_y !== want.coord_y)
                report("coord_y", got.coord_y, want.coord_y);
            if (got.coord_z !== want.coord_z)
                report("coord_z", got.coord_z, want.coord_z);
            if (got.has_neighbor !== want.has_neighbor)
                report("has_neighbor", got.has_neighbor, want.has_neighbor);
            if (got.neighbor_cell !== want.neighbor_cell)
                report("neighbor_cell", got.neighbor_cell, want.neighbor_cell);
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   idle_on;
    bit   hold_rsp;
    bit   hold_done;
    t_nbr_result rsp_seen;
    grid_neighbor_scoreboard sb = new();

    gcni_req_if                          req_ch ();
    gcni_rsp_if #(.DIM_BITS(DIM_BITS))   rsp_ch ();
    gcni_cfg_if                          cfg_ch ();

    grid_cell_neighbor_index_unit #(.DIM_BITS(DIM_BITS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready)
                sb.note_lookup(req_ch.cell_req, req_ch.direction);
            if (cfg_ch.valid && cfg_ch.ready)
                sb.set_size(cfg_ch.index, cfg_ch.data);
            if (rsp_ch.valid && rsp_ch.ready) begin
                rsp_seen.status = rsp_ch.status;
                rsp_seen.coord_x = rsp_ch.coord_x;
                rsp_seen.coord_y = rsp_ch.coord_y;
                rsp_seen.coord_z = rsp_ch.coord_z;
                rsp_seen.has_neighbor = rsp_ch.has_neighbor;
                rsp_seen.neighbor_cell = rsp_ch.neighbor_cell;
                sb.check_result(rsp_seen);
            end
        end
    end

    // receiver: random stall bursts, one long hold on request
    initial begin
        hold_done = 0;
        rsp_ch.ready <= 1'b0;
        repeat (11) @(posedge i_clk);
        forever begin
            if (hold_rsp && !hold_done) begin
                hold_done = 1;
                rsp_ch.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_lookup(input logic [CELL_W-1:0] cell_num,
                               input logic [DIR_W-1:0] dir);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cell_req <= cell_num;
        req_ch.direction <= dir;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // stop offering and wait until every lookup has come back
    task automatic settle_results();
        int waited;
        waited = 0;
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_results.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic program_grid(input logic [REG_W-1:0] x, input logic [REG_W-1:0] y,
                                input logic [REG_W-1:0] z);
        logic [REG_W-1:0] vals [3];
        vals = '{x, y, z};
        cfg_ch.valid <= 1'b1;
        for (int r = 0; r < 3; r++) begin
            cfg_ch.index <= REG_ORDER[r];
            cfg_ch.data <= vals[r];
            do @(posedge i_clk); while (!cfg_ch.ready);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [REG_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return REG_W'($urandom_range(1, 12));
        if (r < 8) return REG_W'($urandom_range(1, 1024));
        return REG_W'($urandom_range(0, 2047));
    endfunction

    function automatic longint unsigned edge_coord(longint unsigned n);
        case ($urandom_range(0, 3))
            0: return 0;
            1: return n - 1;
            default: return $urandom_range(0, int'(n - 1));
        endcase
    endfunction

    function automatic logic [CELL_W-1:0] pick_cell();
        longint unsigned nx, ny, nz, count, c;
        int sel;
        nx = sb.dim(0);
        ny = sb.dim(1);
        nz = sb.dim(2);
        count = nx * ny * nz;
        sel = $urandom_range(0, 9);
        if (count == 0 || sel == 0)
            return CELL_W'($urandom);
        if (sel == 1) begin
            case ($urandom_range(0, 3))
                0: c = count - 1;
                1: c = count;
                2: c = count + $urandom_range(0, 5);
                default: c = 0;
            endcase
            return c[CELL_W-1:0];
        end
        c = (edge_coord(nz) * ny + edge_coord(ny)) * nx + edge_coord(nx);
        return c[CELL_W-1:0];
    endfunction

    function automatic logic [DIR_W-1:0] pick_dir();
        if ($urandom_range(0, 9) == 0) return DIR_W'($urandom_range(6, 7));
        return DIR_W'($urandom_range(0, 5));
    endfunction

    initial begin
        i_rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.cell_req <= '0;
        req_ch.direction <= gcni_pkg::DIR_X_MINUS;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= gcni_pkg::REG_X_SIZE;
        cfg_ch.data <= '0;
        idle_on = 1;
        hold_rsp = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset sizes: single-cell grid, every direction incl. unused codes
        for (int d = 0; d < 8; d++)
            send_lookup('0, DIR_W'(d));
        send_lookup(CELL_W'(1), gcni_pkg::DIR_X_PLUS);
        send_lookup(CELL_MAX, gcni_pkg::DIR_Z_PLUS);
        settle_results();

        // full-size grid, corners and one centre cell
        program_grid(11'd1024, 11'd1024, 11'd1024);
        send_lookup('0, gcni_pkg::DIR_X_MINUS);
        send_lookup('0, gcni_pkg::DIR_Y_MINUS);
        send_lookup('0, gcni_pkg::DIR_Z_MINUS);
        send_lookup(CELL_MAX, gcni_pkg::DIR_X_PLUS);
        send_lookup(CELL_MAX, gcni_pkg::DIR_Y_PLUS);
        send_lookup(CELL_MAX, gcni_pkg::DIR_Z_PLUS);
        send_lookup(CELL_MAX, gcni_pkg::DIR_X_MINUS);
        send_lookup({10'd512, 10'd512, 10'd512}, gcni_pkg::DIR_Z_PLUS);
        settle_results();

        // zero size: empty grid
        program_grid(11'd0, 11'd5, 11'd5);
        send_lookup('0, gcni_pkg::DIR_X_PLUS);
        send_lookup(CELL_W'(7), gcni_pkg::DIR_Y_MINUS);
        settle_results();

        // oversize registers saturate
        program_grid(11'd2047, 11'd2047, 11'd1);
        send_lookup('0, gcni_pkg::DIR_X_PLUS);
        send_lookup(30'h000F_FFFF, gcni_pkg::DIR_Y_PLUS);
        send_lookup(30'h0010_0000, gcni_pkg::DIR_X_MINUS);
        settle_results();

        for (int ph = 0; ph < 12; ph++) begin
            if (ph >= 10)
                idle_on = 0;
            program_grid(pick_dim(), pick_dim(), pick_dim());
            for (int n = 0; n < 100; n++) begin
                if (ph == 2 && n == 5)
                    hold_rsp = 1;
                if (ph == 4 && n == 50)
                    settle_results();
                send_lookup(pick_cell(), pick_dir());
            end
            settle_results();
        end

        if (sb.pending_results.size() != 0)
            sb.report("transfers never returned", sb.pending_results.size(), 0);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
